// ===== rtl/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg
// Types and constants shared by the serial flash command slave.
// ----------------------------------------------------------------------------
package sfc_pkg;

    // input item codes
    typedef enum logic [1:0] {
        CMD_SEL_FALL = 2'd0,
        CMD_SEL_RISE = 2'd1,
        CMD_BYTE     = 2'd2
    } t_cmd;

    // command phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_ADDR   = 6'b000010,
        PH_READ   = 6'b000100,
        PH_PROG   = 6'b001000,
        PH_ID     = 6'b010000,
        PH_STATUS = 6'b100000
    } t_phase;

    // where the result byte of an item comes from
    typedef enum logic [1:0] {
        RES_HOLD = 2'd0,
        RES_BYTE = 2'd1,
        RES_MEM  = 2'd2
    } t_res_kind;

    typedef struct packed {
        t_res_kind  kind;
        logic [7:0] data;
    } t_res;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ADDR_W     = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_OP_READ         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_PROGRAM      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_ERASE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_WRITE_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_READ_STATUS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_READ_ID      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_BYTES        = 3'd6;

    typedef struct packed {
        logic [7:0]  op_read;
        logic [7:0]  op_program;
        logic [7:0]  op_erase;
        logic [7:0]  op_write_enable;
        logic [7:0]  op_read_status;
        logic [7:0]  op_read_id;
        logic [23:0] id_bytes;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        op_read:         8'h03,
        op_program:      8'h02,
        op_erase:        8'h20,
        op_write_enable: 8'h06,
        op_read_status:  8'h05,
        op_read_id:      8'h9F,
        id_bytes:        24'hEF4018
    };

    localparam logic [7:0] STATUS_WEL   = 8'h02;
    localparam logic [7:0] STATUS_CLEAR = 8'h00;
    localparam logic [7:0] ID_FILL      = 8'h00;
    localparam logic [1:0] ADDR_LAST    = 2'd2;
    localparam logic [1:0] ID_LEN       = 2'd3;

endpackage

// ===== rtl/sfc_ifs.sv =====
// ----------------------------------------------------------------------------
// sfc interfaces
// Valid/ready channels of the serial flash command slave.
// ----------------------------------------------------------------------------
interface sfc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] mosi_byte;

    modport source (output valid, output cmd, output mosi_byte, input ready);
    modport sink (input valid, input cmd, input mosi_byte, output ready);
endinterface

interface sfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] miso_byte;

    modport source (output valid, output miso_byte, input ready);
    modport sink (input valid, input miso_byte, output ready);
endinterface

interface sfc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sfc_pkg::CFG_IDX_W-1:0]  index;
    logic [sfc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sfc_store.sv =====
// ----------------------------------------------------------------------------
// sfc_store
// Flash byte store: one port, registered read, zero fill after reset.
// ----------------------------------------------------------------------------
module sfc_store #(
    parameter int MEM_BYTES = 4096,
    parameter int AW        = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd,
    input  logic          i_wr,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_q,
    output logic          o_busy
);
    import sfc_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(MEM_BYTES - 1);

    logic [7:0]    r_mem [MEM_BYTES];
    logic [7:0]    r_q;
    logic          r_busy;
    logic [AW-1:0] r_clr;

    // zero fill sweep, one byte a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            r_clr  <= r_clr + 1'b1;
            r_busy <= (r_clr != LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr] <= '0;
        end else if (i_wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_q    = r_q;
    assign o_busy = r_busy;

endmodule

// ===== rtl/sfc_addr_reduce.sv =====
// ----------------------------------------------------------------------------
// sfc_addr_reduce
// Reduces a 24-bit address modulo the store size in three pipelined steps.
// ----------------------------------------------------------------------------
module sfc_addr_reduce #(
    parameter int MEM_BYTES = 4096,
    parameter int AW        = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_clear,
    input  logic [sfc_pkg::ADDR_W-1:0] i_x,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [AW-1:0]              o_res
);
    import sfc_pkg::*;

    localparam int RW = ADDR_W + 1 - AW;
    localparam int PW = ADDR_W + RW;
    localparam int MW = ADDR_W + 1;
    localparam int QW = RW + MW;
    localparam logic [RW-1:0] RECIP = RW'((2 ** ADDR_W) / MEM_BYTES);
    localparam logic [MW-1:0] MEMC  = MW'(MEM_BYTES);

    logic              r_v1;
    logic              r_v2;
    logic              r_done;
    logic [ADDR_W-1:0] r_x1;
    logic [ADDR_W-1:0] r_x2;
    logic [PW-1:0]     r_p1;
    logic [ADDR_W-1:0] r_p2;
    logic [AW-1:0]     r_res;

    logic [PW-1:0]     w_p1;
    logic [RW-1:0]     w_q;
    logic [QW-1:0]     w_p2;
    logic [ADDR_W-1:0] w_r;
    logic [MW-1:0]     w_sub;
    logic              w_ge;

    // quotient estimate is exact or one low, so one correction step
    assign w_p1  = PW'(i_x) * PW'(RECIP);
    assign w_q   = r_p1[ADDR_W +: RW];
    assign w_p2  = QW'(w_q) * QW'(MEMC);
    assign w_r   = r_x2 - r_p2;
    assign w_ge  = {1'b0, w_r} >= MEMC;
    assign w_sub = {1'b0, w_r} - MEMC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_done <= 1'b1;
            end else if (i_clear) begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x1 <= i_x;
            r_p1 <= w_p1;
        end
        if (r_v1) begin
            r_x2 <= r_x1;
            r_p2 <= w_p2[ADDR_W-1:0];
        end
        if (r_v2) begin
            r_res <= w_ge ? w_sub[AW-1:0] : w_r[AW-1:0];
        end
    end

    assign o_busy = r_v1 | r_v2;
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/sfc_cmd_core.sv =====
// ----------------------------------------------------------------------------
// sfc_cmd_core
// Command state of the flash slave: opcode decode, address, latch, ID count.
// ----------------------------------------------------------------------------
module sfc_cmd_core #(
    parameter int MEM_BYTES = 4096,
    parameter int AW        = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [1:0]                 i_cmd,
    input  logic [7:0]                 i_byte,
    input  sfc_pkg::t_cfg              i_cfg,
    input  logic [AW-1:0]              i_red_addr,
    output logic                       o_need_red,
    output logic [sfc_pkg::ADDR_W-1:0] o_red_x,
    output logic                       o_mem_rd,
    output logic                       o_mem_wr,
    output logic [AW-1:0]              o_mem_addr,
    output logic [7:0]                 o_mem_wdata,
    output sfc_pkg::t_res              o_res
);
    import sfc_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(MEM_BYTES - 1);

    t_phase            r_phase, n_phase;
    t_phase            r_after, n_after;
    logic [1:0]        r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_wel, n_wel;
    logic              r_sel, n_sel;

    logic              w_rd;
    logic              w_wr;
    logic [AW-1:0]     w_cur;
    logic [AW-1:0]     w_next;
    logic [1:0]        w_id_cnt;
    logic [7:0]        w_status;

    assign w_cur    = r_addr[AW-1:0];
    assign w_next   = (w_cur == LAST) ? '0 : w_cur + 1'b1;
    assign w_id_cnt = (r_cnt < ID_LEN) ? r_cnt + 1'b1 : r_cnt;
    assign w_status = r_wel ? STATUS_WEL : STATUS_CLEAR;

    assign o_need_red = (i_cmd == CMD_BYTE) && r_sel && (r_phase == PH_ADDR)
                        && (r_cnt == ADDR_LAST);
    assign o_red_x    = {r_addr[ADDR_W-9:0], i_byte};

    always_comb begin
        n_phase     = r_phase;
        n_after     = r_after;
        n_cnt       = r_cnt;
        n_addr      = r_addr;
        n_wel       = r_wel;
        n_sel       = r_sel;
        w_rd        = 1'b0;
        w_wr        = 1'b0;
        o_mem_addr  = w_cur;
        o_mem_wdata = i_byte;
        o_res.kind  = RES_HOLD;
        o_res.data  = i_byte;
        case (i_cmd)
            CMD_SEL_FALL: begin
                n_phase = PH_IDLE;
                n_cnt   = '0;
                n_addr  = '0;
                n_sel   = 1'b1;
            end
            CMD_SEL_RISE: begin
                n_phase = PH_IDLE;
                n_sel   = 1'b0;
            end
            CMD_BYTE: begin
                if (r_sel) begin
                    o_res.kind = RES_BYTE;
                    case (r_phase)
                        PH_IDLE: begin
                            if (i_byte == i_cfg.op_read_id) begin
                                n_phase    = PH_ID;
                                n_cnt      = '0;
                                o_res.data = i_cfg.id_bytes[23:16];
                            end else if (i_byte == i_cfg.op_read_status) begin
                                n_phase    = PH_STATUS;
                                o_res.data = w_status;
                            end else if (i_byte == i_cfg.op_write_enable) begin
                                n_wel = 1'b1;
                            end else if (i_byte == i_cfg.op_erase && r_wel) begin
                                n_phase = PH_ADDR;
                                n_after = PH_IDLE;
                                n_cnt   = '0;
                                n_addr  = '0;
                                n_wel   = 1'b0;
                            end else if (i_byte == i_cfg.op_program && r_wel) begin
                                n_phase = PH_ADDR;
                                n_after = PH_PROG;
                                n_cnt   = '0;
                                n_addr  = '0;
                                n_wel   = 1'b0;
                            end else if (i_byte == i_cfg.op_read) begin
                                n_phase = PH_ADDR;
                                n_after = PH_READ;
                                n_cnt   = '0;
                                n_addr  = '0;
                            end
                        end
                        PH_ADDR: begin
                            n_cnt = r_cnt + 1'b1;
                            if (r_cnt == ADDR_LAST) begin
                                n_addr  = ADDR_W'(i_red_addr);
                                n_phase = r_after;
                                if (r_after == PH_READ) begin
                                    w_rd       = 1'b1;
                                    o_mem_addr = i_red_addr;
                                    o_res.kind = RES_MEM;
                                end
                            end else begin
                                n_addr = o_red_x;
                            end
                        end
                        PH_READ: begin
                            n_addr     = ADDR_W'(w_next);
                            w_rd       = 1'b1;
                            o_mem_addr = w_next;
                            o_res.kind = RES_MEM;
                        end
                        PH_PROG: begin
                            w_wr   = 1'b1;
                            n_addr = ADDR_W'(w_next);
                        end
                        PH_ID: begin
                            n_cnt = w_id_cnt;
                            if (w_id_cnt == 2'd1) begin
                                o_res.data = i_cfg.id_bytes[15:8];
                            end else if (w_id_cnt == 2'd2) begin
                                o_res.data = i_cfg.id_bytes[7:0];
                            end else begin
                                o_res.data = ID_FILL;
                            end
                        end
                        PH_STATUS: begin
                            o_res.data = w_status;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    assign o_mem_rd = i_fire & w_rd;
    assign o_mem_wr = i_fire & w_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_after <= PH_IDLE;
            r_cnt   <= '0;
            r_addr  <= '0;
            r_wel   <= 1'b0;
            r_sel   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_after <= n_after;
            r_cnt   <= n_cnt;
            r_addr  <= n_addr;
            r_wel   <= n_wel;
            r_sel   <= n_sel;
        end
    end

endmodule

// ===== rtl/spi_flash_command_slave.sv =====
// ----------------------------------------------------------------------------
// spi_flash_command_slave
// Byte-level slave side of a serial NOR flash. Each transfer on the input
// channel is a select edge or one received byte; each yields one transfer on
// the output channel with the byte to shift out next. An item is registered
// in stage A, decoded combinationally, and its result lands in the output
// register, so one item is taken per cycle while the output channel accepts
// and no address is being reduced. The third address byte of a read, program
// or erase waits in stage A while its address is reduced modulo MEM_BYTES.
// After reset the store is swept to zero, one byte per cycle; no item is
// taken during the sweep, configuration writes are.
// ----------------------------------------------------------------------------
module spi_flash_command_slave #(
    parameter int MEM_BYTES = 4096
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sfc_in_if.sink    i_in,
    sfc_out_if.source o_out,
    sfc_cfg_if.sink   i_cfg
);
    import sfc_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    t_cfg          r_cfg;

    logic          r_a_valid;
    logic [1:0]    r_a_cmd;
    logic [7:0]    r_a_byte;

    logic          r_b_valid;
    t_res          r_b_res;
    logic [7:0]    r_shift;

    logic          w_a_fire;
    logic          w_out_fire;
    logic          w_need_red;
    logic          w_red_busy;
    logic          w_red_done;
    logic          w_red_start;
    logic [ADDR_W-1:0] w_red_x;
    logic [AW-1:0] w_red_addr;
    logic          w_mem_rd;
    logic          w_mem_wr;
    logic [AW-1:0] w_mem_addr;
    logic [7:0]    w_mem_wdata;
    logic [7:0]    w_mem_q;
    logic          w_store_busy;
    t_res          w_res;
    logic [7:0]    w_miso;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_OP_READ:         r_cfg.op_read         <= i_cfg.data[7:0];
                CFG_OP_PROGRAM:      r_cfg.op_program      <= i_cfg.data[7:0];
                CFG_OP_ERASE:        r_cfg.op_erase        <= i_cfg.data[7:0];
                CFG_OP_WRITE_ENABLE: r_cfg.op_write_enable <= i_cfg.data[7:0];
                CFG_OP_READ_STATUS:  r_cfg.op_read_status  <= i_cfg.data[7:0];
                CFG_OP_READ_ID:      r_cfg.op_read_id      <= i_cfg.data[7:0];
                CFG_ID_BYTES:        r_cfg.id_bytes        <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // stage A holds the item while its address is being reduced
    assign w_out_fire  = o_out.valid & o_out.ready;
    assign w_a_fire    = r_a_valid & (~w_need_red | w_red_done)
                         & (~r_b_valid | o_out.ready);
    assign w_red_start = r_a_valid & w_need_red & ~w_red_busy & ~w_red_done;
    assign i_in.ready  = (~r_a_valid | w_a_fire) & ~w_store_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_a_valid <= 1'b1;
        end else if (w_a_fire) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_a_cmd  <= i_in.cmd;
            r_a_byte <= i_in.mosi_byte;
        end
    end

    sfc_cmd_core #(
        .MEM_BYTES(MEM_BYTES),
        .AW       (AW)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_a_fire),
        .i_cmd      (r_a_cmd),
        .i_byte     (r_a_byte),
        .i_cfg      (r_cfg),
        .i_red_addr (w_red_addr),
        .o_need_red (w_need_red),
        .o_red_x    (w_red_x),
        .o_mem_rd   (w_mem_rd),
        .o_mem_wr   (w_mem_wr),
        .o_mem_addr (w_mem_addr),
        .o_mem_wdata(w_mem_wdata),
        .o_res      (w_res)
    );

    sfc_addr_reduce #(
        .MEM_BYTES(MEM_BYTES),
        .AW       (AW)
    ) u_reduce (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_red_start),
        .i_clear(w_a_fire),
        .i_x    (w_red_x),
        .o_busy (w_red_busy),
        .o_done (w_red_done),
        .o_res  (w_red_addr)
    );

    sfc_store #(
        .MEM_BYTES(MEM_BYTES),
        .AW       (AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rd   (w_mem_rd),
        .i_wr   (w_mem_wr),
        .i_addr (w_mem_addr),
        .i_wdata(w_mem_wdata),
        .o_q    (w_mem_q),
        .o_busy (w_store_busy)
    );

    // output register; a held result repeats the last byte transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_shift   <= '0;
        end else begin
            if (w_a_fire) begin
                r_b_valid <= 1'b1;
            end else if (w_out_fire) begin
                r_b_valid <= 1'b0;
            end
            if (w_out_fire) begin
                r_shift <= w_miso;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_fire) begin
            r_b_res <= w_res;
        end
    end

    always_comb begin
        case (r_b_res.kind)
            RES_MEM:  w_miso = w_mem_q;
            RES_BYTE: w_miso = r_b_res.data;
            default:  w_miso = r_shift;
        endcase
    end

    assign o_out.valid     = r_b_valid;
    assign o_out.miso_byte = w_miso;

`ifndef SYNTHESIS
    a_no_item_during_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_store_busy |-> !i_in.ready)
        else $error("item taken while the store is being cleared");

    a_address_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_a_fire && w_need_red) |-> w_red_done)
        else $error("address byte retired before its reduction finished");

    a_single_mem_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_rd && w_mem_wr))
        else $error("store read and written in the same cycle");

    a_mem_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_res.kind == RES_MEM && !o_out.ready) |=> $stable(w_mem_q))
        else $error("store read data changed under a stalled result");
`endif

endmodule

// ===== tb/tb_spi_flash_command_slave.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spi_flash_command_slave
// Drives select edges and host bytes into the flash command slave and checks
// every returned miso byte against a byte-level model of the flash commands.
// The model keeps its own opcode settings and store. The run covers a short
// directed sequence and then random command sessions under several opcode
// settings, with random stalls on the item and result channels.
// ----------------------------------------------------------------------------
module tb_spi_flash_command_slave;
    import sfc_pkg::*;

    localparam int MEM_BYTES = 4096;

    logic i_clk;
    logic i_rst_n;

    sfc_in_if  in_ch ();
    sfc_out_if out_ch ();
    sfc_cfg_if cfg_ch ();

    spi_flash_command_slave #(.MEM_BYTES(MEM_BYTES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // byte-level model of the command decoder plus the queue of miso bytes due
    class miso_tracker;
        t_cfg        regs;
        t_phase      phase;
        t_phase      phase_after;
        logic [7:0]  count;
        logic [23:0] addr;
        logic        wel;
        logic        selected;
        logic [7:0]  miso_hold;
        logic [7:0]  store [MEM_BYTES];
        logic [7:0]  miso_due [$];
        int          errors;

        function new();
            regs        = CFG_RESET;
            phase       = PH_IDLE;
            phase_after = PH_IDLE;
            count       = '0;
            addr        = '0;
            wel         = 1'b0;
            selected    = 1'b0;
            miso_hold   = '0;
            errors      = 0;
            foreach (store[i]) store[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_OP_READ:         regs.op_read         = d[7:0];
                CFG_OP_PROGRAM:      regs.op_program      = d[7:0];
                CFG_OP_ERASE:        regs.op_erase        = d[7:0];
                CFG_OP_WRITE_ENABLE: regs.op_write_enable = d[7:0];
                CFG_OP_READ_STATUS:  regs.op_read_status  = d[7:0];
                CFG_OP_READ_ID:      regs.op_read_id      = d[7:0];
                CFG_ID_BYTES:        regs.id_bytes        = d;
                default: ;
            endcase
        endfunction

        function logic [23:0] step_addr(logic [23:0] a);
            return (a + 24'd1 >= MEM_BYTES) ? 24'd0 : a + 24'd1;
        endfunction

        function void start_addr(t_phase nxt);
            phase       = PH_ADDR;
            phase_after = nxt;
            count       = '0;
            addr        = '0;
        endfunction

        function logic [7:0] exchange(logic [7:0] b);
            logic [7:0] r;
            r = b;
            case (phase)
                PH_IDLE: begin
                    // opcode match order matters when settings collide
                    if (b == regs.op_read_id) begin
                        phase = PH_ID;
                        count = '0;
                        r     = regs.id_bytes[23:16];
                    end else if (b == regs.op_read_status) begin
                        phase = PH_STATUS;
                        r     = wel ? STATUS_WEL : STATUS_CLEAR;
                    end else if (b == regs.op_write_enable) begin
                        wel = 1'b1;
                    end else if (b == regs.op_erase && wel) begin
                        start_addr(PH_IDLE);
                        wel = 1'b0;
                    end else if (b == regs.op_program && wel) begin
                        start_addr(PH_PROG);
                        wel = 1'b0;
                    end else if (b == regs.op_read) begin
                        start_addr(PH_READ);
                    end
                end
                PH_ADDR: begin
                    addr  = {addr[15:0], b};
                    count = count + 8'd1;
                    if (count >= 8'd3) begin
                        addr  = addr % MEM_BYTES;
                        phase = phase_after;
                        if (phase == PH_READ) r = store[addr];
                    end
                end
                PH_READ: begin
                    addr = step_addr(addr);
                    r    = store[addr];
                end
                PH_PROG: begin
                    store[addr] = b;
                    addr        = step_addr(addr);
                end
                PH_ID: begin
                    if (count < 8'd3) count = count + 8'd1;
                    if (count == 8'd1)      r = regs.id_bytes[15:8];
                    else if (count == 8'd2) r = regs.id_bytes[7:0];
                    else                    r = ID_FILL;
                end
                PH_STATUS: r = wel ? STATUS_WEL : STATUS_CLEAR;
                default: phase = PH_IDLE;
            endcase
            return r;
        endfunction

        function void take_item(t_cmd c, logic [7:0] b);
            case (c)
                CMD_SEL_FALL: begin
                    phase    = PH_IDLE;
                    count    = '0;
                    addr     = '0;
                    selected = 1'b1;
                end
                CMD_SEL_RISE: begin
                    phase    = PH_IDLE;
                    selected = 1'b0;
                end
                CMD_BYTE: if (selected) miso_hold = exchange(b);
                default: ;
            endcase
            miso_due.push_back(miso_hold);
        endfunction

        function void check_miso(logic [7:0] got);
            logic [7:0] want;
            if (miso_due.size() == 0) begin
                $display("%0t: miso byte %02h with none expected", $time, got);
                errors++;
            end else begin
                want = miso_due.pop_front();
                if (got !== want) begin
                    $display("%0t: miso expected %02h, got %02h", $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return miso_due.size();
        endfunction
    endclass

    miso_tracker tracker = new();

    int items_sent = 0;
    int calm_mark  = 32'h7fff_ffff;
    bit calm       = 1'b0;
    bit gappy      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("spi_flash_command_slave: mismatch");
        $finish;
    end

    // result side: random stall bursts; the stall chance is redrawn from 0, 15 and 30 percent
    initial begin
        int cyc;
        int pct;
        cyc = 0;
        pct = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (cyc % 64 == 0) pct = $urandom_range(0, 2) * 15;
            cyc++;
            if (!calm && $urandom_range(1, 100) <= pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) tracker.check_miso(out_ch.miso_byte);
    end

    task automatic send(t_cmd c, logic [7:0] b);
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= c;
        in_ch.mosi_byte <= b;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        tracker.take_item(c, b);
        items_sent++;
        calm = (items_sent >= calm_mark);
        if (gappy && !calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(logic [7:0] b);
        send(CMD_BYTE, b);
    endtask

    // wait for every miso byte, then let the address reduction settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apply_settings(t_cfg c, bit pad);
        logic [CFG_IDX_W-1:0]  idx  [7];
        logic [CFG_DATA_W-1:0] vals [7];
        idx  = '{CFG_OP_READ, CFG_OP_PROGRAM, CFG_OP_ERASE, CFG_OP_WRITE_ENABLE,
                 CFG_OP_READ_STATUS, CFG_OP_READ_ID, CFG_ID_BYTES};
        vals = '{{16'h0, c.op_read}, {16'h0, c.op_program}, {16'h0, c.op_erase},
                 {16'h0, c.op_write_enable}, {16'h0, c.op_read_status},
                 {16'h0, c.op_read_id}, c.id_bytes};
        for (int i = 0; i < 7; i++) begin
            // opcode registers only keep the low byte
            if (pad && i < 6) vals[i][23:8] = 16'($urandom);
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= vals[i];
            do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
            tracker.write_reg(idx[i], vals[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // middle byte mostly lands near the bottom or top of the store
    function automatic logic [7:0] addr_byte(int pos);
        logic [7:0] v;
        v = 8'($urandom);
        if (pos == 1 && $urandom_range(0, 3) != 0) v[3:0] = $urandom_range(0, 1) ? 4'hF : 4'h0;
        return v;
    endfunction

    function automatic logic [7:0] pick_opcode();
        case ($urandom_range(0, 6))
            0: return tracker.regs.op_read;
            1: return tracker.regs.op_program;
            2: return tracker.regs.op_erase;
            3: return tracker.regs.op_write_enable;
            4: return tracker.regs.op_read_status;
            5: return tracker.regs.op_read_id;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_address(int n);
        for (int i = 0; i < n; i++) send_byte(addr_byte(i));
    endtask

    task automatic random_session();
        int kind;
        int n;
        kind  = $urandom_range(0, 99);
        gappy = ($urandom_range(0, 3) != 0);
        // short address phase now and then: broken command
        n     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 3;
        send(CMD_SEL_FALL, 8'($urandom));
        if (kind < 10) begin
            send_byte(tracker.regs.op_read_id);
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom));
        end else if (kind < 20) begin
            if ($urandom_range(0, 1)) send_byte(tracker.regs.op_write_enable);
            send_byte(tracker.regs.op_read_status);
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end else if (kind < 45) begin
            if ($urandom_range(0, 9) != 0) send_byte(tracker.regs.op_write_enable);
            send_byte(tracker.regs.op_program);
            send_address(n);
            if (n == 3) repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
        end else if (kind < 70) begin
            send_byte(tracker.regs.op_read);
            send_address(n);
            if (n == 3) repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
        end else if (kind < 80) begin
            if ($urandom_range(0, 9) != 0) send_byte(tracker.regs.op_write_enable);
            send_byte(tracker.regs.op_erase);
            send_address(n);
            // erase falls back to opcode decode within the same select
            repeat ($urandom_range(0, 2)) send_byte(pick_opcode());
        end else begin
            repeat ($urandom_range(1, 6)) send(t_cmd'($urandom_range(0, 2)), 8'($urandom));
        end
        if ($urandom_range(0, 9) != 0) send(CMD_SEL_RISE, 8'($urandom));
    endtask

    task automatic run_random(int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at) random_session();
    endtask

    task automatic directed_run();
        // byte while deselected
        send_byte(8'hFF);
        // id read, then fill byte once the three id bytes are out
        send(CMD_SEL_FALL, 8'h00);
        send_byte(CFG_RESET.op_read_id);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        // program at the top address, wrapping to zero
        send(CMD_SEL_FALL, 8'hFF);
        send_byte(CFG_RESET.op_write_enable);
        send_byte(CFG_RESET.op_program);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(8'h55);
        // read back across the wrap
        send(CMD_SEL_FALL, 8'h00);
        send_byte(CFG_RESET.op_read);
        send_byte(8'h00);
        send_byte(8'h0F);
        send_byte(8'hFF);
        send_byte(8'h00);
        // erase clears the latch, status shows it
        send(CMD_SEL_FALL, 8'h00);
        send_byte(CFG_RESET.op_write_enable);
        send_byte(CFG_RESET.op_erase);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(CFG_RESET.op_read_status);
        send(CMD_SEL_RISE, 8'hFF);
    endtask

    initial begin
        t_cfg c;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.cmd       <= CMD_BYTE;
        in_ch.mosi_byte <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_run();
        run_random(170);

        drain();
        c = '{op_read: 8'hFF, op_program: 8'h00, op_erase: 8'h80, op_write_enable: 8'h01,
              op_read_status: 8'hFE, op_read_id: 8'h7F, id_bytes: 24'hFFFFFF};
        apply_settings(c, 1'b0);
        run_random(160);

        // read, program and erase share one opcode: decode order decides
        drain();
        c = '{op_read: 8'h00, op_program: 8'h00, op_erase: 8'h00, op_write_enable: 8'hFF,
              op_read_status: 8'h01, op_read_id: 8'h80, id_bytes: 24'h000000};
        apply_settings(c, 1'b0);
        run_random(160);

        drain();
        c = '{op_read: 8'($urandom), op_program: 8'($urandom), op_erase: 8'($urandom),
              op_write_enable: 8'($urandom), op_read_status: 8'($urandom),
              op_read_id: 8'($urandom), id_bytes: 24'($urandom)};
        apply_settings(c, 1'b1);
        calm_mark = items_sent + 60;
        run_random(160);

        drain();
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("spi_flash_command_slave: match");
        end else begin
            $display("spi_flash_command_slave: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sfc_pkg.sv
rtl/sfc_ifs.sv
rtl/sfc_store.sv
rtl/sfc_addr_reduce.sv
rtl/sfc_cmd_core.sv
rtl/spi_flash_command_slave.sv
tb/tb_spi_flash_command_slave.sv
